// ----- rtl/pto_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pto_pkg
// Shared types and constants for the peer table: widths, request modes, the
// scan record that travels along the row of cells, and the write command.
// ----------------------------------------------------------------------------
package pto_pkg;

  localparam int TableSize = 16;
  localparam int SlotW     = $clog2(TableSize);
  localparam int CountW    = $clog2(TableSize + 1);
  localparam int AddrW     = 48;
  localparam int StrW      = 8;
  localparam int TimeW     = 32;
  localparam int IdxW      = 4;
  localparam int OutSlotW  = 4;
  localparam int OutCountW = 5;

  typedef enum logic [1:0] {
    MODE_UPSERT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                   active;
    mode_e                  mode;
    logic [AddrW-1:0]       addr;
    logic [IdxW-1:0]        want;
    logic                   have;
    logic                   known;
    logic [SlotW-1:0]       target;
    logic                   old_any;
    logic [SlotW-1:0]       old_idx;
    logic [TimeW-1:0]       old_seen;
    logic                   rd_hit;
    logic [IdxW-1:0]        rd_count;
    logic [AddrW-1:0]       rd_addr;
    logic signed [StrW-1:0] rd_str;
    logic [TimeW-1:0]       rd_seen;
  } carrier_t;

  typedef struct packed {
    logic                   en;
    logic                   clr;
    logic [SlotW-1:0]       slot;
    logic [AddrW-1:0]       addr;
    logic signed [StrW-1:0] strength;
    logic [TimeW-1:0]       seen;
  } wr_t;

endpackage
`default_nettype wire

// ----- rtl/pto_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pto_cell
// One table entry. It merges its entry into the passing scan record and hands
// the record, registered, to the next cell. It takes writes and clears.
// ----------------------------------------------------------------------------
module pto_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [pto_pkg::SlotW-1:0] idx_i,
  input  wire pto_pkg::carrier_t        carry_i,
  output pto_pkg::carrier_t             carry_o,
  input  wire pto_pkg::wr_t             wr_i
);
  import pto_pkg::*;

  logic                   valid_q;
  logic [AddrW-1:0]       addr_q;
  logic signed [StrW-1:0] str_q;
  logic [TimeW-1:0]       seen_q;
  carrier_t               carry_d;
  carrier_t               carry_q;

  always_comb begin
    carry_d = carry_i;
    if (carry_i.active) begin
      case (carry_i.mode)
        MODE_UPSERT: begin
          if (!carry_i.known) begin
            if (valid_q && (addr_q == carry_i.addr)) begin
              carry_d.target = idx_i;
              carry_d.have   = 1'b1;
              carry_d.known  = 1'b1;
            end else begin
              if (!valid_q && !carry_i.have) begin
                carry_d.target = idx_i;
                carry_d.have   = 1'b1;
              end
              if (!carry_i.old_any || (seen_q < carry_i.old_seen)) begin
                carry_d.old_any  = 1'b1;
                carry_d.old_idx  = idx_i;
                carry_d.old_seen = seen_q;
              end
            end
          end
        end
        MODE_READ: begin
          if (valid_q && !carry_i.rd_hit) begin
            if (carry_i.rd_count == carry_i.want) begin
              carry_d.rd_hit  = 1'b1;
              carry_d.target  = idx_i;
              carry_d.rd_addr = addr_q;
              carry_d.rd_str  = str_q;
              carry_d.rd_seen = seen_q;
            end else begin
              carry_d.rd_count = carry_i.rd_count + IdxW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
      valid_q <= 1'b0;
    end else begin
      carry_q <= carry_d;
      if (wr_i.clr) begin
        valid_q <= 1'b0;
      end else if (wr_i.en && (wr_i.slot == idx_i)) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_i.clr && (wr_i.slot == idx_i)) begin
      addr_q <= wr_i.addr;
      str_q  <= wr_i.strength;
      seen_q <= wr_i.seen;
    end
  end

  assign carry_o = carry_q;

endmodule
`default_nettype wire

// ----- rtl/peer_table_oldest_replace.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// peer_table_oldest_replace
// Peer table keyed by station address with oldest-timestamp replacement.
//
// The request channel (in_valid_i / in_stall_o) carries a mode, an address,
// a signal strength, a time stamp and a peer ordinal. Upsert refreshes a
// matching entry, else fills the lowest free slot, else replaces the entry
// with the smallest time stamp. Read returns the nth valid entry in slot
// order. Clear empties the table. The result channel (out_valid_o /
// out_stall_i) returns one result per request with the valid entry count.
// A request walks the row of TableSize cells one cell per cycle. The request
// channel stalls until the request has been committed, so a new request is
// not taken while one is in the cells; the next one is accepted while a
// result still waits in the output register. While an earlier result is
// stalled, the finished scan is held and the block waits before writing the
// table. Reset empties the table and leaves no result pending.
// ----------------------------------------------------------------------------
module peer_table_oldest_replace (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    mode_i,
  input  wire logic [pto_pkg::AddrW-1:0]     station_addr_i,
  input  wire logic signed [pto_pkg::StrW-1:0] signal_strength_i,
  input  wire logic [pto_pkg::TimeW-1:0]     time_now_i,
  input  wire logic [pto_pkg::IdxW-1:0]      peer_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [pto_pkg::OutSlotW-1:0]       slot_o,
  output logic                               was_known_o,
  output logic                               found_o,
  output logic [pto_pkg::AddrW-1:0]          peer_addr_o,
  output logic signed [pto_pkg::StrW-1:0]    peer_strength_o,
  output logic [pto_pkg::TimeW-1:0]          peer_seen_o,
  output logic [pto_pkg::OutCountW-1:0]      valid_count_o
);
  import pto_pkg::*;

  state_e                 state_q, state_d;
  carrier_t               head_d, head_q;
  carrier_t               hold_d, hold_q;
  carrier_t               chain [TableSize+1];
  logic [TableSize:0]     act;
  wr_t                    wr;
  logic [CountW-1:0]      cnt_d, cnt_q;
  logic signed [StrW-1:0] req_str_q;
  logic [TimeW-1:0]       req_now_q;
  logic                   commit;
  logic                   out_valid_d, out_valid_q;
  logic [SlotW-1:0]       up_slot;
  logic [OutSlotW-1:0]    slot_d, slot_q;
  logic                   known_d, known_q;
  logic                   found_d, found_q;
  logic [AddrW-1:0]       paddr_d, paddr_q;
  logic signed [StrW-1:0] pstr_d, pstr_q;
  logic [TimeW-1:0]       pseen_d, pseen_q;

  assign chain[0] = head_q;

  for (genvar i = 0; i < TableSize; i++) begin : g_cell
    pto_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (SlotW'(i)),
      .carry_i (chain[i]),
      .carry_o (chain[i+1]),
      .wr_i    (wr)
    );
  end

  for (genvar i = 0; i <= TableSize; i++) begin : g_act
    assign act[i] = chain[i].active;
  end

  assign up_slot = hold_q.have ? hold_q.target : hold_q.old_idx;

  always_comb begin
    state_d     = state_q;
    head_d      = '0;
    hold_d      = hold_q;
    commit      = 1'b0;
    in_stall_o  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          head_d.active = 1'b1;
          head_d.mode   = mode_e'(mode_i);
          head_d.addr   = station_addr_i;
          head_d.want   = peer_index_i;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain[TableSize].active) begin
          hold_d  = chain[TableSize];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    wr          = '0;
    wr.slot     = up_slot;
    wr.addr     = hold_q.addr;
    wr.strength = req_str_q;
    wr.seen     = req_now_q;
    cnt_d       = cnt_q;
    slot_d      = '0;
    known_d     = 1'b0;
    found_d     = 1'b0;
    paddr_d     = '0;
    pstr_d      = '0;
    pseen_d     = '0;
    out_valid_d = out_valid_q && out_stall_i;
    if (commit) begin
      out_valid_d = 1'b1;
      case (hold_q.mode)
        MODE_UPSERT: begin
          wr.en   = 1'b1;
          slot_d  = OutSlotW'(up_slot);
          known_d = hold_q.known;
          if (hold_q.have && !hold_q.known) begin
            cnt_d = cnt_q + CountW'(1);
          end
        end
        MODE_READ: begin
          if (hold_q.rd_hit) begin
            slot_d  = OutSlotW'(hold_q.target);
            found_d = 1'b1;
            paddr_d = hold_q.rd_addr;
            pstr_d  = hold_q.rd_str;
            pseen_d = hold_q.rd_seen;
          end
        end
        MODE_CLEAR: begin
          wr.clr = 1'b1;
          cnt_d  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      hold_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      hold_q      <= hold_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_str_q <= signal_strength_i;
      req_now_q <= time_now_i;
    end
    if (commit) begin
      slot_q  <= slot_d;
      known_q <= known_d;
      found_q <= found_d;
      paddr_q <= paddr_d;
      pstr_q  <= pstr_d;
      pseen_q <= pseen_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign slot_o          = slot_q;
  assign was_known_o     = known_q;
  assign found_o         = found_q;
  assign peer_addr_o     = paddr_q;
  assign peer_strength_o = pstr_q;
  assign peer_seen_o     = pseen_q;
  assign valid_count_o   = OutCountW'(cnt_q);

  a_one_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(act) <= 1)
    else $error("More than one request is travelling through the cells.");

  a_tail_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[TableSize].active |-> (state_q == ST_SCAN))
    else $error("A scan left the last cell outside the scan state.");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(TableSize))
    else $error("The valid entry count exceeds the table size.");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("A result appeared without a finished scan.");

endmodule
`default_nettype wire

// ----- tb/peer_table_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peer_table_checker
// Watches the request and result channels of the peer table. Each accepted
// request is run through a local copy of the table to work out the result it
// must produce, and every accepted result is compared field by field with the
// oldest result still awaited.
// ----------------------------------------------------------------------------
module peer_table_checker (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  input  wire logic                                   in_stall_i,
  input  wire logic [1:0]                             mode_i,
  input  wire logic [pto_pkg::AddrW-1:0]              station_addr_i,
  input  wire logic signed [pto_pkg::StrW-1:0]        signal_strength_i,
  input  wire logic [pto_pkg::TimeW-1:0]              time_now_i,
  input  wire logic [pto_pkg::IdxW-1:0]               peer_index_i,
  input  wire logic                                   out_valid_i,
  input  wire logic                                   out_stall_i,
  input  wire logic [pto_pkg::OutSlotW-1:0]           slot_i,
  input  wire logic                                   was_known_i,
  input  wire logic                                   found_i,
  input  wire logic [pto_pkg::AddrW-1:0]              peer_addr_i,
  input  wire logic signed [pto_pkg::StrW-1:0]        peer_strength_i,
  input  wire logic [pto_pkg::TimeW-1:0]              peer_seen_i,
  input  wire logic [pto_pkg::OutCountW-1:0]          valid_count_i,
  output int                                          mismatch_count_o,
  output int                                          pending_o,
  output int                                          checked_o,
  output int                                          evictions_o
);

  import pto_pkg::*;

  localparam int MaxReports = 10;

  typedef struct {
    logic [OutSlotW-1:0]    slot;
    logic                   was_known;
    logic                   found;
    logic [AddrW-1:0]       addr;
    logic signed [StrW-1:0] strength;
    logic [TimeW-1:0]       seen;
    logic [OutCountW-1:0]   count;
  } peer_result_t;

  logic                   valid_tab    [TableSize];
  logic [AddrW-1:0]       addr_tab     [TableSize];
  logic signed [StrW-1:0] strength_tab [TableSize];
  logic [TimeW-1:0]       seen_tab     [TableSize];

  peer_result_t awaited_results[$];
  int           errors;
  int           checked;
  int           evictions;

  function automatic void clear_peers();
    for (int i = 0; i < TableSize; i++) begin
      valid_tab[i]    = 1'b0;
      addr_tab[i]     = '0;
      strength_tab[i] = '0;
      seen_tab[i]     = '0;
    end
  endfunction

  function automatic int count_peers();
    int n;
    n = 0;
    for (int i = 0; i < TableSize; i++) begin
      if (valid_tab[i]) begin
        n++;
      end
    end
    return n;
  endfunction

  function automatic peer_result_t apply_peer_request(mode_e m, logic [AddrW-1:0] a,
                                                      logic signed [StrW-1:0] s,
                                                      logic [TimeW-1:0] t,
                                                      logic [IdxW-1:0] k);
    peer_result_t     r;
    int               target;
    int               oldest;
    int               ordinal;
    logic             have;
    logic             known;
    logic [TimeW-1:0] min_seen;
    logic [31:0]      n_valid;
    r = '{default: '0};
    case (m)
      MODE_UPSERT: begin
        target   = 0;
        have     = 1'b0;
        known    = 1'b0;
        oldest   = 0;
        min_seen = seen_tab[0];
        for (int i = 0; i < TableSize; i++) begin
          if (valid_tab[i] && addr_tab[i] == a) begin
            target = i;
            have   = 1'b1;
            known  = 1'b1;
            break;
          end
          if (!valid_tab[i] && !have) begin
            target = i;
            have   = 1'b1;
          end
          if (seen_tab[i] < min_seen) begin
            min_seen = seen_tab[i];
            oldest   = i;
          end
        end
        if (!have) begin
          target = oldest;
          evictions++;
        end
        valid_tab[target]    = 1'b1;
        addr_tab[target]     = a;
        strength_tab[target] = s;
        seen_tab[target]     = t;
        r.slot      = OutSlotW'(target);
        r.was_known = known;
      end
      MODE_READ: begin
        ordinal = 0;
        for (int i = 0; i < TableSize; i++) begin
          if (valid_tab[i]) begin
            if (ordinal == int'(k)) begin
              r.slot     = OutSlotW'(i);
              r.found    = 1'b1;
              r.addr     = addr_tab[i];
              r.strength = strength_tab[i];
              r.seen     = seen_tab[i];
              break;
            end
            ordinal++;
          end
        end
      end
      MODE_CLEAR: begin
        clear_peers();
      end
      default: begin
      end
    endcase
    n_valid = count_peers();
    r.count = n_valid[OutCountW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    peer_result_t want;
    peer_result_t got;
    if (!rst_ni) begin
      clear_peers();
      awaited_results.delete();
      errors           = 0;
      checked          = 0;
      evictions        = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
      checked_o        <= 0;
      evictions_o      <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{slot: slot_i, was_known: was_known_i, found: found_i, addr: peer_addr_i,
                strength: peer_strength_i, seen: peer_seen_i, count: valid_count_i};
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= MaxReports) begin
            $display("%0t: result with no request outstanding: slot %0d count %0d",
                     $realtime, slot_i, valid_count_i);
          end
        end else begin
          want = awaited_results.pop_front();
          checked++;
          if (got.slot !== want.slot || got.was_known !== want.was_known ||
              got.found !== want.found || got.addr !== want.addr ||
              got.strength !== want.strength || got.seen !== want.seen ||
              got.count !== want.count) begin
            errors++;
            if (errors <= MaxReports) begin
              $display("%0t: result %0d expected slot %0d known %0b found %0b count %0d",
                       $realtime, checked, want.slot, want.was_known, want.found,
                       want.count);
              $display("%0t: result %0d expected addr %h str %0d seen %h",
                       $realtime, checked, want.addr, want.strength, want.seen);
              $display("%0t: result %0d actual   slot %0d known %0b found %0b count %0d",
                       $realtime, checked, got.slot, got.was_known, got.found,
                       got.count);
              $display("%0t: result %0d actual   addr %h str %0d seen %h",
                       $realtime, checked, got.addr, got.strength, got.seen);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(apply_peer_request(mode_e'(mode_i), station_addr_i,
                                                     signal_strength_i, time_now_i,
                                                     peer_index_i));
      end
      mismatch_count_o <= errors;
      pending_o        <= awaited_results.size();
      checked_o        <= checked;
      evictions_o      <= evictions;
    end
  end

endmodule

// ----- tb/tb_peer_table_oldest_replace.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_peer_table_oldest_replace
// Drives upsert, read, clear and unused requests into the peer table, with
// random idle bursts on the request side and random stall bursts on the
// result side. A directed opening covers field extremes and the full-table
// replacement cases; the random part works a small pool of addresses so the
// table fills, refreshes and evicts. The checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_peer_table_oldest_replace;

  import pto_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int RandomCount   = 1125;
  localparam int QuietFrom     = 975;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             mode_i = MODE_NONE;
  logic [AddrW-1:0]       station_addr_i = '0;
  logic signed [StrW-1:0] signal_strength_i = '0;
  logic [TimeW-1:0]       time_now_i = '0;
  logic [IdxW-1:0]        peer_index_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [OutSlotW-1:0]    slot_o;
  logic                   was_known_o;
  logic                   found_o;
  logic [AddrW-1:0]       peer_addr_o;
  logic signed [StrW-1:0] peer_strength_o;
  logic [TimeW-1:0]       peer_seen_o;
  logic [OutCountW-1:0]   valid_count_o;

  int mismatches;
  int pending;
  int checked;
  int evictions;

  logic quiet = 1'b0;
  int   gap_pct = 10;
  int   stall_left = 0;
  int   idle_cycles = 0;

  int n_upsert = 0;
  int n_read   = 0;
  int n_clear  = 0;
  int n_none   = 0;

  logic [AddrW-1:0] addr_pool [24];
  logic [TimeW-1:0] clock_ms;

  peer_table_oldest_replace DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .station_addr_i    (station_addr_i),
    .signal_strength_i (signal_strength_i),
    .time_now_i        (time_now_i),
    .peer_index_i      (peer_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .slot_o            (slot_o),
    .was_known_o       (was_known_o),
    .found_o           (found_o),
    .peer_addr_o       (peer_addr_o),
    .peer_strength_o   (peer_strength_o),
    .peer_seen_o       (peer_seen_o),
    .valid_count_o     (valid_count_o)
  );

  peer_table_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .mode_i            (mode_i),
    .station_addr_i    (station_addr_i),
    .signal_strength_i (signal_strength_i),
    .time_now_i        (time_now_i),
    .peer_index_i      (peer_index_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .slot_i            (slot_o),
    .was_known_i       (was_known_o),
    .found_i           (found_o),
    .peer_addr_i       (peer_addr_o),
    .peer_strength_i   (peer_strength_o),
    .peer_seen_i       (peer_seen_o),
    .valid_count_i     (valid_count_o),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending),
    .checked_o         (checked),
    .evictions_o       (evictions)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      stall_left  <= $urandom_range(1, 12);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Timeout: nothing moved on either channel for %0d cycles.", WatchdogLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_request(input mode_e m, input logic [AddrW-1:0] a,
                              input logic signed [StrW-1:0] s, input logic [TimeW-1:0] t,
                              input logic [IdxW-1:0] k);
    in_valid_i        <= 1'b1;
    mode_i            <= m;
    station_addr_i    <= a;
    signal_strength_i <= s;
    time_now_i        <= t;
    peer_index_i      <= k;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    case (m)
      MODE_UPSERT: n_upsert++;
      MODE_READ:   n_read++;
      MODE_CLEAR:  n_clear++;
      default:     n_none++;
    endcase
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending != 0);
  endtask

  function automatic logic [AddrW-1:0] any_addr();
    return AddrW'({$urandom, $urandom});
  endfunction

  function automatic logic signed [StrW-1:0] rand_str();
    return StrW'($urandom);
  endfunction

  function automatic logic [IdxW-1:0] rand_idx();
    return IdxW'($urandom);
  endfunction

  initial begin
    int          pick;
    logic [AddrW-1:0] a;
    logic [TimeW-1:0] t;
    for (int i = 0; i < 24; i++) begin
      addr_pool[i] = any_addr();
    end
    clock_ms = $urandom;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(MODE_READ, any_addr(), rand_str(), $urandom, 4'd0);
    send_request(MODE_NONE, any_addr(), rand_str(), $urandom, rand_idx());
    send_request(MODE_UPSERT, '0, -8'sd128, '0, rand_idx());
    send_request(MODE_UPSERT, '1, 8'sd127, '1, rand_idx());
    send_request(MODE_UPSERT, '1, -8'sd1, 32'h8000_0000, rand_idx());
    send_request(MODE_READ, any_addr(), rand_str(), $urandom, 4'd1);
    send_request(MODE_READ, any_addr(), rand_str(), $urandom, 4'd15);
    send_request(MODE_CLEAR, any_addr(), rand_str(), $urandom, rand_idx());
    // Every entry stamped with the largest time: the next new peer evicts slot 0.
    for (int i = 0; i < TableSize; i++) begin
      send_request(MODE_UPSERT, {addr_pool[i][AddrW-1:4], 4'(i)}, rand_str(), '1, rand_idx());
    end
    send_request(MODE_UPSERT, any_addr(), rand_str(), $urandom, rand_idx());
    send_request(MODE_READ, any_addr(), rand_str(), $urandom, 4'd15);
    send_request(MODE_NONE, any_addr(), rand_str(), $urandom, rand_idx());
    drain_results();

    for (int n = 0; n < RandomCount; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct <= 0;
          1:       gap_pct <= 10;
          default: gap_pct <= 35;
        endcase
      end
      if (n == QuietFrom) begin
        quiet <= 1'b1;
      end
      if (n == 300 || n == 700) begin
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_request(MODE_CLEAR, any_addr(), rand_str(), $urandom, rand_idx());
      end else if (pick < 5) begin
        send_request(MODE_NONE, any_addr(), rand_str(), $urandom, rand_idx());
      end else if (pick < 32) begin
        send_request(MODE_READ, any_addr(), rand_str(), $urandom, rand_idx());
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          a = addr_pool[$urandom_range(0, 23)];
        end else if (pick == 8) begin
          a = any_addr();
        end else begin
          addr_pool[$urandom_range(0, 23)] = any_addr();
          a = addr_pool[$urandom_range(0, 23)];
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          clock_ms = clock_ms + $urandom_range(0, 40);
          t = clock_ms;
        end else if (pick == 7) begin
          t = $urandom;
        end else if (pick == 8) begin
          t = clock_ms;
        end else begin
          t = '1;
        end
        send_request(MODE_UPSERT, a, rand_str(), t, rand_idx());
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d requests: %0d upserts, %0d reads, %0d clears, %0d of the unused mode.",
             n_upsert + n_read + n_clear + n_none, n_upsert, n_read, n_clear, n_none);
    $display("Compared %0d results; %0d upserts replaced the oldest entry of a full table.",
             checked, evictions);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
